@@ hw/rtl/cr3_pkg.sv @@
package cr3_pkg;

   // coordinate and internal widths
   localparam int CRD_W    = 32;
   localparam int PT_W     = 35;
   localparam int KN_W     = 37;
   localparam int OPA_W    = 64;
   localparam int OPB_W    = KN_W + 1;
   localparam int REM_W    = OPB_W + 1;
   localparam int NUM_W    = 104;
   localparam int SQ_W     = 70;
   localparam int ROOT_W   = SQ_W / 2;
   localparam int CNT_W    = 7;

   // iteration counts of the shared unit
   localparam int MUL_STEPS  = OPB_W;
   localparam int DIV_STEPS  = NUM_W;
   localparam int SQRT_STEPS = ROOT_W;

   // configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 6;
   localparam int TYPE_W     = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEGMENTS   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURVE_TYPE = 1'b1;
   localparam logic [CSR_DATA_W-1:0] SEG_RESET      = 6'd8;

   // knot spacing codes
   localparam logic [TYPE_W-1:0] CT_UNIFORM     = 2'd0;
   localparam logic [TYPE_W-1:0] CT_CENTRIPETAL = 2'd1;
   localparam logic [TYPE_W-1:0] CT_CHORDAL     = 2'd2;

   localparam logic [KN_W-1:0]  ONE_Q16   = KN_W'(65536);
   localparam logic [NUM_W-1:0] MID_LIMIT = {{(NUM_W-63){1'b0}}, 1'b1, 62'b0};

   // loop ends of the sequencer
   localparam logic [1:0] LAST_CRD    = 2'd2;
   localparam logic [1:0] LAST_KNOT   = 2'd2;
   localparam logic [2:0] LAST_INTERP = 3'd5;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } cr3_op_type;

   typedef enum logic [1:0] {
      AU_IDLE,
      AU_RUN,
      AU_FIX,
      AU_DONE
   } cr3_au_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ECHO,
      ST_LIN_MUL,
      ST_LIN_DIV,
      ST_LIN_EMIT,
      ST_KN_MUL,
      ST_KN_SQ,
      ST_KN_CSQ,
      ST_KN_NEXT,
      ST_DEG_EMIT,
      ST_T_MUL,
      ST_T_DIV,
      ST_I_MUL1,
      ST_I_MUL2,
      ST_I_DIV,
      ST_PT_EMIT,
      ST_SPAN_END,
      ST_WIN
   } cr3_state_type;

   typedef struct packed {
      logic                    start;
      cr3_op_type              op;
      logic signed [OPA_W-1:0] opa;
      logic signed [OPB_W-1:0] opb;
      logic signed [NUM_W-1:0] num;
      logic                    rnd;
   } cr3_au_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [NUM_W-1:0] res;
   } cr3_au_rsp_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [CRD_W-1:0] z;
      logic                    run_end;
      logic                    degenerate;
   } cr3_beat_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [CRD_W-1:0] sat32(input logic signed [OPA_W-1:0] v);
      logic signed [CRD_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[CRD_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/cr3_arith.sv @@
module cr3_arith (
   input  logic                    clock,
   input  logic                    reset,
   input  cr3_pkg::cr3_au_req_type au_req,
   output cr3_pkg::cr3_au_rsp_type au_rsp
);
   import cr3_pkg::*;

   cr3_au_state_type st_ff, st_in;
   cr3_op_type       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] wide_ff, wide_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [OPA_W-1:0] opnd_ff, opnd_in;
   logic             neg_ff, neg_in;
   logic signed [NUM_W-1:0] res_ff, res_in;

   logic [OPA_W-1:0] mag_a;
   logic [OPB_W-1:0] mag_b;
   logic [NUM_W-1:0] mag_n;
   logic [REM_W-1:0] div_rt, div_den, sq_rt, sq_trial;
   logic             div_ge, sq_ge;
   logic [NUM_W-1:0] q_sat;

   // operand magnitudes
   assign mag_a = au_req.opa[OPA_W-1] ? OPA_W'(-au_req.opa) : OPA_W'(au_req.opa);
   assign mag_b = au_req.opb[OPB_W-1] ? OPB_W'(-au_req.opb) : OPB_W'(au_req.opb);
   assign mag_n = au_req.num[NUM_W-1] ? NUM_W'(-au_req.num) : NUM_W'(au_req.num);

   // restoring divide step
   assign div_rt  = {rem_ff[OPB_W-1:0], wide_ff[NUM_W-1]};
   assign div_den = {1'b0, opnd_ff[OPB_W-1:0]};
   assign div_ge  = div_rt >= div_den;

   // digit-by-digit root step
   assign sq_rt    = {rem_ff[REM_W-3:0], wide_ff[SQ_W-1 -: 2]};
   assign sq_trial = {2'b00, opnd_ff[ROOT_W-1:0], 2'b01};
   assign sq_ge    = sq_rt >= sq_trial;

   assign q_sat = (wide_ff > MID_LIMIT) ? MID_LIMIT : wide_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         AU_IDLE: if (au_req.start) st_in = AU_RUN;
         AU_RUN:  if (cnt_ff == '0) st_in = AU_FIX;
         AU_FIX:  st_in = AU_DONE;
         AU_DONE: st_in = AU_IDLE;
         default: st_in = AU_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      au_rsp.done = (st_ff == AU_DONE);
      au_rsp.res  = res_ff;
   end

   // datapath
   always_comb begin
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      wide_in = wide_ff;
      rem_in  = rem_ff;
      opnd_in = opnd_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      case (st_ff)
         AU_IDLE: begin
            if (au_req.start) begin
               op_in = au_req.op;
               case (au_req.op)
                  OP_MUL: begin
                     opnd_in = mag_a;
                     rem_in  = {1'b0, mag_b};
                     wide_in = '0;
                     neg_in  = au_req.opa[OPA_W-1] ^ au_req.opb[OPB_W-1];
                     cnt_in  = CNT_W'(MUL_STEPS - 1);
                  end
                  OP_DIV: begin
                     opnd_in = OPA_W'(unsigned'(au_req.opb));
                     rem_in  = '0;
                     wide_in = mag_n + (au_req.rnd ?
                               NUM_W'(unsigned'(au_req.opb) >> 1) : '0);
                     neg_in  = au_req.num[NUM_W-1];
                     cnt_in  = CNT_W'(DIV_STEPS - 1);
                  end
                  default: begin
                     opnd_in = '0;
                     rem_in  = '0;
                     wide_in = NUM_W'(au_req.num[SQ_W-1:0]);
                     neg_in  = 1'b0;
                     cnt_in  = CNT_W'(SQRT_STEPS - 1);
                  end
               endcase
            end
         end
         AU_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            case (op_ff)
               OP_MUL: begin
                  wide_in = {wide_ff[NUM_W-2:0], 1'b0} +
                            (rem_ff[OPB_W-1] ? NUM_W'(opnd_ff) : '0);
                  rem_in  = {rem_ff[REM_W-2:0], 1'b0};
               end
               OP_DIV: begin
                  rem_in  = div_ge ? (div_rt - div_den) : div_rt;
                  wide_in = {wide_ff[NUM_W-2:0], div_ge};
               end
               default: begin
                  rem_in  = sq_ge ? (sq_rt - sq_trial) : sq_rt;
                  opnd_in = {opnd_ff[OPA_W-2:0], sq_ge};
                  wide_in = {wide_ff[NUM_W-3:0], 2'b00};
               end
            endcase
         end
         AU_FIX: begin
            case (op_ff)
               OP_MUL:  res_in = neg_ff ? -$signed(wide_ff) : $signed(wide_ff);
               OP_DIV:  res_in = neg_ff ? -$signed(q_sat) : $signed(q_sat);
               default: res_in = $signed(NUM_W'(opnd_ff[ROOT_W-1:0]));
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= AU_IDLE;
         op_ff <= OP_MUL;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         op_ff <= op_in;
         cnt_ff <= cnt_in;
      end
      wide_ff <= wide_in;
      rem_ff  <= rem_in;
      opnd_ff <= opnd_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      au_req.start |-> st_ff == AU_IDLE)
      else $error("shared unit started while busy");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      au_rsp.done |=> !au_rsp.done)
      else $error("done held longer than one cycle");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (au_rsp.done && op_ff == OP_DIV) |->
      (au_rsp.res <= $signed(MID_LIMIT) && au_rsp.res >= -$signed(MID_LIMIT)))
      else $error("quotient beyond saturation bound");
`endif

endmodule

@@ hw/rtl/cr3_ctrl.sv @@
module cr3_ctrl #(
   parameter int MAX_SEGMENTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [cr3_pkg::CRD_W-1:0]     in_x,
   input  logic signed [cr3_pkg::CRD_W-1:0]     in_y,
   input  logic signed [cr3_pkg::CRD_W-1:0]     in_z,
   input  logic                                 in_fin,
   input  logic [$clog2(MAX_SEGMENTS+1)-1:0]    seg,
   input  logic [cr3_pkg::TYPE_W-1:0]           ctype,
   input  logic                                 emit_ok,
   output logic                                 emit_valid,
   output cr3_pkg::cr3_beat_type                emit_beat,
   output cr3_pkg::cr3_au_req_type              au_req,
   input  cr3_pkg::cr3_au_rsp_type              au_rsp
);
   import cr3_pkg::*;

   localparam int SEG_W = $clog2(MAX_SEGMENTS+1);

   cr3_state_type state_ff, state_in;

   logic signed [CRD_W-1:0] pnt_ff [3], pnt_in [3];
   logic                    fin_ff, fin_in;
   logic signed [CRD_W-1:0] win_ff [3][3], win_in [3][3];
   logic [1:0]              ps_ff, ps_in;
   logic signed [PT_W-1:0]  pt_ff [4][3], pt_in [4][3];
   logic [KN_W-1:0]         knot_ff [3], knot_in [3];
   logic [KN_W-1:0]         step_ff, step_in;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [KN_W-1:0]         t_ff, t_in;
   logic signed [NUM_W-1:0] prod_ff, prod_in;
   logic signed [OPA_W-1:0] tmp_ff [5], tmp_in [5];
   logic signed [OPA_W-1:0] crv_ff [3], crv_in [3];
   logic [1:0]              j_ff, j_in, crd_ff, crd_in;
   logic [2:0]              n_ff, n_in;
   logic [SEG_W-1:0]        i_ff, i_in;
   logic                    second_ff, second_in, deg_ff, deg_in, pend_ff, pend_in;

   logic [KN_W-1:0]         kn [4];
   logic signed [OPA_W-1:0] sel_p, sel_q;
   logic [1:0]              sel_a, sel_b;
   logic signed [OPB_W-1:0] b_minus_t, t_minus_a, den_i, kdiff, i_ext, seg_ext;
   logic signed [OPA_W-1:0] lin_diff, span_k;
   logic [ROOT_W-1:0]       root;
   logic                    deg_now, last_i, last_span, op_state;

   assign kn[0] = '0;
   assign kn[1] = knot_ff[0];
   assign kn[2] = knot_ff[1];
   assign kn[3] = knot_ff[2];

   // operands of the six interpolations of the pyramid
   always_comb begin
      sel_p = OPA_W'(pt_ff[0][crd_ff]);
      sel_q = OPA_W'(pt_ff[1][crd_ff]);
      sel_a = 2'd0;
      sel_b = 2'd1;
      case (n_ff)
         3'd0: begin
            sel_p = OPA_W'(pt_ff[0][crd_ff]); sel_q = OPA_W'(pt_ff[1][crd_ff]);
            sel_a = 2'd0; sel_b = 2'd1;
         end
         3'd1: begin
            sel_p = OPA_W'(pt_ff[1][crd_ff]); sel_q = OPA_W'(pt_ff[2][crd_ff]);
            sel_a = 2'd1; sel_b = 2'd2;
         end
         3'd2: begin
            sel_p = OPA_W'(pt_ff[2][crd_ff]); sel_q = OPA_W'(pt_ff[3][crd_ff]);
            sel_a = 2'd2; sel_b = 2'd3;
         end
         3'd3: begin
            sel_p = tmp_ff[0]; sel_q = tmp_ff[1];
            sel_a = 2'd0; sel_b = 2'd2;
         end
         3'd4: begin
            sel_p = tmp_ff[1]; sel_q = tmp_ff[2];
            sel_a = 2'd1; sel_b = 2'd3;
         end
         default: begin
            sel_p = tmp_ff[3]; sel_q = tmp_ff[4];
            sel_a = 2'd1; sel_b = 2'd2;
         end
      endcase
   end

   assign b_minus_t = $signed({1'b0, kn[sel_b]}) - $signed({1'b0, t_ff});
   assign t_minus_a = $signed({1'b0, t_ff}) - $signed({1'b0, kn[sel_a]});
   assign den_i     = $signed({1'b0, kn[sel_b]}) - $signed({1'b0, kn[sel_a]});
   assign kdiff     = OPB_W'(pt_ff[j_ff + 2'd1][crd_ff]) - OPB_W'(pt_ff[j_ff][crd_ff]);
   assign i_ext     = $signed({{(OPB_W-SEG_W){1'b0}}, i_ff});
   assign seg_ext   = $signed({{(OPB_W-SEG_W){1'b0}}, seg});
   assign lin_diff  = OPA_W'(pnt_ff[crd_ff]) - OPA_W'(win_ff[2][crd_ff]);
   assign span_k    = $signed({{(OPA_W-KN_W){1'b0}}, kn[2] - kn[1]});
   assign root      = au_rsp.res[ROOT_W-1:0];
   assign deg_now   = deg_ff | (step_ff == '0);
   assign last_i    = (i_ff == seg);
   assign last_span = !fin_ff || second_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (in_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (ps_ff == 2'd0) begin
               state_in = ST_ECHO;
            end else if (ps_ff == 2'd1) begin
               state_in = fin_ff ? ST_LIN_MUL : ST_WIN;
            end else begin
               state_in = ST_KN_MUL;
            end
         end
         ST_ECHO:     if (emit_ok) state_in = ST_WIN;
         ST_LIN_MUL:  if (au_rsp.done) state_in = ST_LIN_DIV;
         ST_LIN_DIV:  if (au_rsp.done) state_in = (crd_ff == LAST_CRD) ? ST_LIN_EMIT : ST_LIN_MUL;
         ST_LIN_EMIT: if (emit_ok) state_in = last_i ? ST_WIN : ST_LIN_MUL;
         ST_KN_MUL:   if (au_rsp.done) state_in = (crd_ff == LAST_CRD) ? ST_KN_SQ : ST_KN_MUL;
         ST_KN_SQ: begin
            if (au_rsp.done) begin
               if (root == '0 || ctype == CT_UNIFORM || ctype == CT_CHORDAL) begin
                  state_in = ST_KN_NEXT;
               end else begin
                  state_in = ST_KN_CSQ;
               end
            end
         end
         ST_KN_CSQ:   if (au_rsp.done) state_in = ST_KN_NEXT;
         ST_KN_NEXT: begin
            if (j_ff == LAST_KNOT) begin
               state_in = deg_now ? ST_DEG_EMIT : ST_T_MUL;
            end else begin
               state_in = ST_KN_MUL;
            end
         end
         ST_DEG_EMIT: if (emit_ok && last_i) state_in = ST_SPAN_END;
         ST_T_MUL:    if (au_rsp.done) state_in = ST_T_DIV;
         ST_T_DIV:    if (au_rsp.done) state_in = ST_I_MUL1;
         ST_I_MUL1:   if (au_rsp.done) state_in = ST_I_MUL2;
         ST_I_MUL2:   if (au_rsp.done) state_in = ST_I_DIV;
         ST_I_DIV: begin
            if (au_rsp.done) begin
               if (n_ff == LAST_INTERP && crd_ff == LAST_CRD) begin
                  state_in = ST_PT_EMIT;
               end else begin
                  state_in = ST_I_MUL1;
               end
            end
         end
         ST_PT_EMIT:  if (emit_ok) state_in = last_i ? ST_SPAN_END : ST_T_MUL;
         ST_SPAN_END: state_in = (fin_ff && !second_ff) ? ST_KN_MUL : ST_WIN;
         ST_WIN:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs: shared unit requests and result beats
   always_comb begin
      in_ready   = (state_ff == ST_IDLE);
      op_state   = 1'b0;
      au_req.op  = OP_MUL;
      au_req.opa = '0;
      au_req.opb = '0;
      au_req.num = '0;
      au_req.rnd = 1'b0;
      case (state_ff)
         ST_LIN_MUL: begin
            op_state = 1'b1; au_req.opa = lin_diff; au_req.opb = i_ext;
         end
         ST_LIN_DIV, ST_T_DIV: begin
            op_state = 1'b1; au_req.op = OP_DIV; au_req.num = prod_ff; au_req.opb = seg_ext;
         end
         ST_KN_MUL: begin
            op_state = 1'b1; au_req.opa = OPA_W'(kdiff); au_req.opb = kdiff;
         end
         ST_KN_SQ, ST_KN_CSQ: begin
            op_state = 1'b1; au_req.op = OP_SQRT; au_req.num = $signed(NUM_W'(acc_ff));
         end
         ST_T_MUL: begin
            op_state = 1'b1; au_req.opa = span_k; au_req.opb = i_ext;
         end
         ST_I_MUL1: begin
            op_state = 1'b1; au_req.opa = sel_p; au_req.opb = b_minus_t;
         end
         ST_I_MUL2: begin
            op_state = 1'b1; au_req.opa = sel_q; au_req.opb = t_minus_a;
         end
         ST_I_DIV: begin
            op_state = 1'b1; au_req.op = OP_DIV; au_req.num = prod_ff;
            au_req.opb = den_i; au_req.rnd = 1'b1;
         end
         default: begin
         end
      endcase
      au_req.start = op_state && !pend_ff;

      emit_valid           = 1'b0;
      emit_beat.x          = sat32(crv_ff[0]);
      emit_beat.y          = sat32(crv_ff[1]);
      emit_beat.z          = sat32(crv_ff[2]);
      emit_beat.run_end    = 1'b0;
      emit_beat.degenerate = 1'b0;
      case (state_ff)
         ST_ECHO: begin
            emit_valid        = 1'b1;
            emit_beat.x       = pnt_ff[0];
            emit_beat.y       = pnt_ff[1];
            emit_beat.z       = pnt_ff[2];
            emit_beat.run_end = 1'b1;
         end
         ST_LIN_EMIT: begin
            emit_valid        = 1'b1;
            emit_beat.run_end = last_i;
         end
         ST_DEG_EMIT: begin
            emit_valid           = 1'b1;
            emit_beat.x          = sat32(OPA_W'(pt_ff[1][0]));
            emit_beat.y          = sat32(OPA_W'(pt_ff[1][1]));
            emit_beat.z          = sat32(OPA_W'(pt_ff[1][2]));
            emit_beat.run_end    = last_i && last_span;
            emit_beat.degenerate = 1'b1;
         end
         ST_PT_EMIT: begin
            emit_valid        = 1'b1;
            emit_beat.run_end = last_i && last_span;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      pnt_in = pnt_ff;  fin_in = fin_ff;  win_in = win_ff;  ps_in = ps_ff;
      pt_in = pt_ff;    knot_in = knot_ff; step_in = step_ff; acc_in = acc_ff;
      t_in = t_ff;      prod_in = prod_ff; tmp_in = tmp_ff;   crv_in = crv_ff;
      j_in = j_ff;      crd_in = crd_ff;   n_in = n_ff;       i_in = i_ff;
      second_in = second_ff; deg_in = deg_ff;
      pend_in = pend_ff;
      if (au_req.start) pend_in = 1'b1;
      if (au_rsp.done)  pend_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               pnt_in[0] = in_x; pnt_in[1] = in_y; pnt_in[2] = in_z;
               fin_in = in_fin;
            end
         end
         ST_DISPATCH: begin
            i_in = SEG_W'(1); crd_in = '0; j_in = '0; acc_in = '0;
            deg_in = 1'b0; second_in = 1'b0;
            for (int k = 0; k < 3; k++) begin
               if (ps_ff == 2'd2) begin
                  pt_in[0][k] = PT_W'(2 * PT_W'(win_ff[1][k])) - PT_W'(win_ff[2][k]);
               end else begin
                  pt_in[0][k] = PT_W'(win_ff[0][k]);
               end
               pt_in[1][k] = PT_W'(win_ff[1][k]);
               pt_in[2][k] = PT_W'(win_ff[2][k]);
               pt_in[3][k] = PT_W'(pnt_ff[k]);
            end
         end
         ST_LIN_MUL, ST_T_MUL, ST_I_MUL1: if (au_rsp.done) prod_in = au_rsp.res;
         ST_I_MUL2: if (au_rsp.done) prod_in = prod_ff + au_rsp.res;
         ST_LIN_DIV: begin
            if (au_rsp.done) begin
               crv_in[crd_ff] = OPA_W'(win_ff[2][crd_ff]) + au_rsp.res[OPA_W-1:0];
               crd_in = (crd_ff == LAST_CRD) ? 2'd0 : crd_ff + 2'd1;
            end
         end
         ST_LIN_EMIT, ST_DEG_EMIT, ST_PT_EMIT: begin
            if (emit_ok && !last_i) i_in = i_ff + 1'b1;
         end
         ST_KN_MUL: begin
            if (au_rsp.done) begin
               acc_in = acc_ff + au_rsp.res[SQ_W-1:0];
               crd_in = (crd_ff == LAST_CRD) ? 2'd0 : crd_ff + 2'd1;
            end
         end
         ST_KN_SQ: begin
            if (au_rsp.done) begin
               if (root == '0) begin
                  step_in = '0;
               end else begin
                  case (ctype)
                     CT_UNIFORM: step_in = ONE_Q16;
                     CT_CHORDAL: step_in = KN_W'(root);
                     default:    acc_in  = SQ_W'({root, 16'b0});
                  endcase
               end
            end
         end
         ST_KN_CSQ: if (au_rsp.done) step_in = KN_W'(root);
         ST_KN_NEXT: begin
            knot_in[j_ff] = kn[j_ff] + step_ff;
            deg_in = deg_now;
            acc_in = '0;
            j_in = (j_ff == LAST_KNOT) ? 2'd0 : j_ff + 2'd1;
         end
         ST_T_DIV: begin
            if (au_rsp.done) begin
               t_in = kn[1] + au_rsp.res[KN_W-1:0];
               crd_in = '0; n_in = '0;
            end
         end
         ST_I_DIV: begin
            if (au_rsp.done) begin
               if (n_ff == LAST_INTERP) begin
                  crv_in[crd_ff] = au_rsp.res[OPA_W-1:0];
                  n_in = '0;
                  crd_in = (crd_ff == LAST_CRD) ? 2'd0 : crd_ff + 2'd1;
               end else begin
                  tmp_in[n_ff] = au_rsp.res[OPA_W-1:0];
                  n_in = n_ff + 3'd1;
               end
            end
         end
         ST_SPAN_END: begin
            // second span with the mirrored end point
            if (fin_ff && !second_ff) begin
               second_in = 1'b1; i_in = SEG_W'(1); crd_in = '0; j_in = '0;
               acc_in = '0; deg_in = 1'b0;
               for (int k = 0; k < 3; k++) begin
                  pt_in[0][k] = pt_ff[1][k];
                  pt_in[1][k] = pt_ff[2][k];
                  pt_in[2][k] = pt_ff[3][k];
                  pt_in[3][k] = PT_W'(2 * pt_ff[3][k]) - pt_ff[2][k];
               end
            end
         end
         ST_WIN: begin
            for (int k = 0; k < 3; k++) begin
               win_in[0][k] = win_ff[1][k];
               win_in[1][k] = win_ff[2][k];
               win_in[2][k] = pnt_ff[k];
            end
            if (fin_ff) begin
               ps_in = 2'd0;
            end else if (ps_ff != 2'd3) begin
               ps_in = ps_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ps_ff     <= '0;
         pend_ff   <= 1'b0;
         j_ff      <= '0;
         crd_ff    <= '0;
         n_ff      <= '0;
         i_ff      <= '0;
         second_ff <= 1'b0;
         deg_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[s][k] <= '0;
            end
         end
      end else begin
         state_ff  <= state_in;
         ps_ff     <= ps_in;
         pend_ff   <= pend_in;
         j_ff      <= j_in;
         crd_ff    <= crd_in;
         n_ff      <= n_in;
         i_ff      <= i_in;
         second_ff <= second_in;
         deg_ff    <= deg_in;
         fin_ff    <= fin_in;
         win_ff    <= win_in;
      end
      pnt_ff  <= pnt_in;
      pt_ff   <= pt_in;
      knot_ff <= knot_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      crv_ff  <= crv_in;
   end

`ifndef SYNTHESIS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      au_rsp.done |-> pend_ff)
      else $error("unit result without a pending request");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> state_ff == ST_DISPATCH)
      else $error("accepted point not dispatched");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (emit_valid && !emit_ok) |=> (emit_valid && $stable(emit_beat)))
      else $error("blocked beat changed");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIN && fin_ff) |=> ps_ff == 2'd0)
      else $error("point count kept after final point");
`endif

endmodule

@@ hw/rtl/catmull_rom_curve_3d.sv @@
// channel  | handshake           | payload
// req      | req_valid/req_stall | req_point_x/y/z, req_final_point
// rsp      | rsp_valid/rsp_stall | rsp_curve_x/y/z, rsp_run_end, rsp_degenerate
// csr      | csr_we              | csr_addr, csr_wdata
//
// one point at a time; req_stall stays high until its last beat, if any, sits in the output register
// shared unit: multiply, divide and root, each as start, run, fix, done
// per point: t by mul+div, 18 interpolations of 2 mul+div each; up to 2*segments points
// first point: dispatch, echo, window update; second non-final: dispatch, window update
// reset is synchronous; it clears the point window and loads 8 segments, centripetal
// rsp_stall holds the sequencer only at the output register; the unit is not stalled
module catmull_rom_curve_3d #(
   parameter int MAX_SEGMENTS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [cr3_pkg::CRD_W-1:0]     req_point_x,
   input  logic signed [cr3_pkg::CRD_W-1:0]     req_point_y,
   input  logic signed [cr3_pkg::CRD_W-1:0]     req_point_z,
   input  logic                                 req_final_point,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [cr3_pkg::CRD_W-1:0]     rsp_curve_x,
   output logic signed [cr3_pkg::CRD_W-1:0]     rsp_curve_y,
   output logic signed [cr3_pkg::CRD_W-1:0]     rsp_curve_z,
   output logic                                 rsp_run_end,
   output logic                                 rsp_degenerate,
   input  logic                                 csr_we,
   input  logic [cr3_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [cr3_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cr3_pkg::*;

   localparam int SEG_W = $clog2(MAX_SEGMENTS+1);

   logic [CSR_DATA_W-1:0] seg_ff, seg_in;
   logic [TYPE_W-1:0]     type_ff, type_in;
   logic [SEG_W-1:0]      seg_eff;
   logic                  in_ready, emit_valid, emit_ok;
   cr3_beat_type          emit_beat, beat_ff, beat_in;
   logic                  valid_ff, valid_in;
   cr3_au_req_type        au_req;
   cr3_au_rsp_type        au_rsp;

   // configuration registers
   always_comb begin
      seg_in  = seg_ff;
      type_in = type_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_SEGMENTS:   seg_in  = csr_wdata;
            CSR_CURVE_TYPE: type_in = csr_wdata[TYPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // segment count limited to 1..MAX_SEGMENTS
   always_comb begin
      if (seg_ff == '0) begin
         seg_eff = SEG_W'(1);
      end else if (seg_ff > CSR_DATA_W'(MAX_SEGMENTS)) begin
         seg_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         seg_eff = SEG_W'(seg_ff);
      end
   end

   assign req_stall = !in_ready;

   // output register between sequencer and result channel
   assign emit_ok = !valid_ff || !rsp_stall;
   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (emit_valid && emit_ok) begin
         valid_in = 1'b1;
         beat_in  = emit_beat;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_curve_x    = beat_ff.x;
   assign rsp_curve_y    = beat_ff.y;
   assign rsp_curve_z    = beat_ff.z;
   assign rsp_run_end    = beat_ff.run_end;
   assign rsp_degenerate = beat_ff.degenerate;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= SEG_RESET;
         type_ff  <= CT_CENTRIPETAL;
         valid_ff <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         type_ff  <= type_in;
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   cr3_ctrl #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (in_ready),
      .in_x       (req_point_x),
      .in_y       (req_point_y),
      .in_z       (req_point_z),
      .in_fin     (req_final_point),
      .seg        (seg_eff),
      .ctype      (type_ff),
      .emit_ok    (emit_ok),
      .emit_valid (emit_valid),
      .emit_beat  (emit_beat),
      .au_req     (au_req),
      .au_rsp     (au_rsp)
   );

   cr3_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .au_req (au_req),
      .au_rsp (au_rsp)
   );

endmodule
